FILE: src/wrsi_pkg.sv
`default_nettype none

package wrsi_pkg;

    localparam int PRICE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 11;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 10'd2;

    localparam int CLOSE_W     = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    localparam int RSI_W           = 15;
    localparam int RSI_FRAC_BITS   = 8;
    localparam int NORM_LIMIT_BITS = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_WDIV,
        ST_SDIFF,
        ST_SDIV,
        ST_NORM,
        ST_RATIO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } pdiv_stat_t;

endpackage

`default_nettype wire

FILE: src/wrsi_pdiv.sv
`default_nettype none

module wrsi_pdiv #(
    parameter int WIDTH = wrsi_pkg::PRICE_BITS_DEF + wrsi_pkg::FRACTION_BITS_DEF
                          + wrsi_pkg::PERIOD_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [WIDTH-1:0]              dividend,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0] divisor,
    output logic      [WIDTH-1:0]              quotient,
    output wrsi_pkg::pdiv_stat_t               stat
);

    localparam int PW    = wrsi_pkg::PERIOD_W;
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] q_reg, q_next;
    logic [PW-1:0]    r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PW:0]      trial;
    logic             fits;

    // one quotient bit per cycle, msb first
    always_comb
    begin
        trial     = {r_reg, q_reg[WIDTH-1]};
        fits      = trial >= {1'b0, divisor};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[WIDTH-2:0], fits};
            r_next   = fits ? PW'(trial - {1'b0, divisor}) : trial[PW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quotient    = q_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = r_reg != '0;

endmodule

`default_nettype wire

FILE: src/wrsi_ratio.sv
`default_nettype none

module wrsi_ratio (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [wrsi_pkg::NORM_LIMIT_BITS-1:0] gain,
    input  wire logic [wrsi_pkg::NORM_LIMIT_BITS-1:0] loss,
    output logic      [wrsi_pkg::RSI_W-1:0]           rsi,
    output logic                                      done
);

    localparam int NW     = wrsi_pkg::NORM_LIMIT_BITS;
    localparam int RW     = wrsi_pkg::RSI_W;
    localparam int FRAC   = wrsi_pkg::RSI_FRAC_BITS;
    localparam int SUM_W  = NW + 1;
    localparam int PROD_W = NW + 7;
    localparam int LOW_W  = RW - FRAC;
    localparam int CNT_W  = $clog2(RW + 1);

    logic [PROD_W-1:0] g100;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W:0]    trial;
    logic              fits;

    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  s_reg, s_next;
    logic [RW-1:0]     nq_reg, nq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // numerator is (gain * 100) << 8, only its low RW bits are fed serially
    always_comb
    begin
        g100  = (PROD_W'(gain) << 6) + (PROD_W'(gain) << 5) + (PROD_W'(gain) << 2);
        sum   = SUM_W'(gain) + SUM_W'(loss);
        trial = {rem_reg, nq_reg[RW-1]};
        fits  = trial >= {1'b0, s_reg};
        rem_next  = rem_reg;
        s_next    = s_reg;
        nq_next   = nq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = SUM_W'(g100 >> LOW_W);
            nq_next   = {g100[LOW_W-1:0], {FRAC{1'b0}}};
            s_next    = sum;
            cnt_next  = CNT_W'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            nq_next  = {nq_reg[RW-2:0], fits};
            rem_next = fits ? SUM_W'(trial - {1'b0, s_reg}) : trial[SUM_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        s_reg   <= s_next;
        nq_reg  <= nq_next;
    end

    assign rsi  = nq_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: src/wilder_rsi_tracker_top.sv
// one request at a time; the next request is taken once the result sits in the output register
// warm-up bars: the first bar goes straight to the result, later ones pass through the accumulate state
// last warm-up bar: also waits for the bit-serial divide by the period
// later bars: smoothing divide by the period, normalizing shifts, then the bit-serial ratio divide
// later bars with both averages zero: no ratio divide
// asynchronous active-low reset clears close history, warm-up count and averages; period -> 14
`default_nettype none

module wilder_rsi_tracker_top #(
    parameter int PRICE_BITS    = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0]   cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wrsi_pkg::S_TDATA_W-1:0]  s_tdata,   // close_price
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [wrsi_pkg::M_TDATA_W-1:0]  m_tdata,   // rsi_value, pad
    output logic      [wrsi_pkg::M_TUSER_W-1:0]  m_tuser    // valid_res, flat
);

    localparam int PW       = wrsi_pkg::PERIOD_W;
    localparam int CW       = wrsi_pkg::COUNT_W;
    localparam int RW       = wrsi_pkg::RSI_W;
    localparam int NW       = wrsi_pkg::NORM_LIMIT_BITS;
    localparam int AVG_BITS = PRICE_BITS + FRACTION_BITS + PW;

    wrsi_pkg::state_t state_reg, state_next;

    logic [PW-1:0]         period_reg;
    logic [PRICE_BITS-1:0] prev_reg, prev_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AVG_BITS-1:0]   avg_g_reg, avg_g_next, avg_l_reg, avg_l_next;
    logic [PRICE_BITS-1:0] diff_reg, diff_next;
    logic                  up_reg, up_next;
    logic                  ge_g_reg, ge_g_next, ge_l_reg, ge_l_next;
    logic [AVG_BITS-1:0]   ng_reg, ng_next, nl_reg, nl_next;
    logic [RW-1:0]         res_rsi_reg, res_rsi_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_flat_reg, res_flat_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [RW-1:0]         m_rsi_reg, m_rsi_next;
    logic                  m_valid_res_reg, m_valid_res_next;
    logic                  m_flat_reg, m_flat_next;

    logic [PW-1:0]         p_eff;
    logic [CW-1:0]         p_ext;
    logic [PRICE_BITS-1:0] close_in;
    logic                  close_up;
    logic [AVG_BITS-1:0]   mv_g, mv_l;
    logic [AVG_BITS:0]     sum_g, sum_l;
    logic [AVG_BITS-1:0]   sat_g, sat_l;
    logic                  sm_ge_g, sm_ge_l;
    logic [AVG_BITS-1:0]   sm_d_g, sm_d_l;
    logic [AVG_BITS-1:0]   sm_new_g, sm_new_l;
    logic                  both_zero, need_shift;

    logic                  div_start;
    logic [AVG_BITS-1:0]   div_in_g, div_in_l;
    logic [AVG_BITS-1:0]   div_q_g, div_q_l;
    wrsi_pkg::pdiv_stat_t  div_st_g, div_st_l;
    logic                  div_done;

    logic                  rat_start;
    logic [RW-1:0]         rat_q;
    logic                  rat_done;

    // shared arithmetic
    always_comb
    begin
        p_eff    = (period_reg < wrsi_pkg::PERIOD_MIN) ? wrsi_pkg::PERIOD_MIN : period_reg;
        p_ext    = {1'b0, p_eff};
        close_in = PRICE_BITS'(s_tdata);
        close_up = close_in > prev_reg;
        mv_g     = up_reg ? (AVG_BITS'(diff_reg) << FRACTION_BITS) : '0;
        mv_l     = up_reg ? '0 : (AVG_BITS'(diff_reg) << FRACTION_BITS);
        sum_g    = {1'b0, avg_g_reg} + {1'b0, mv_g};
        sum_l    = {1'b0, avg_l_reg} + {1'b0, mv_l};
        sat_g    = sum_g[AVG_BITS] ? '1 : sum_g[AVG_BITS-1:0];
        sat_l    = sum_l[AVG_BITS] ? '1 : sum_l[AVG_BITS-1:0];
        sm_ge_g  = mv_g >= avg_g_reg;
        sm_ge_l  = mv_l >= avg_l_reg;
        sm_d_g   = sm_ge_g ? mv_g - avg_g_reg : avg_g_reg - mv_g;
        sm_d_l   = sm_ge_l ? mv_l - avg_l_reg : avg_l_reg - mv_l;
        // the new average rounds down: floor of the step on the way up, ceil on the way down
        sm_new_g = ge_g_reg ? avg_g_reg + div_q_g
                            : avg_g_reg - div_q_g - AVG_BITS'(div_st_g.rem_nz);
        sm_new_l = ge_l_reg ? avg_l_reg + div_q_l
                            : avg_l_reg - div_q_l - AVG_BITS'(div_st_l.rem_nz);
        both_zero  = (ng_reg == '0) && (nl_reg == '0);
        need_shift = ((ng_reg >> NW) != '0) || ((nl_reg >> NW) != '0);
        div_in_g   = (state_reg == wrsi_pkg::ST_ACC) ? sat_g : sm_d_g;
        div_in_l   = (state_reg == wrsi_pkg::ST_ACC) ? sat_l : sm_d_l;
        div_done   = div_st_g.done & div_st_l.done;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (count_reg > p_ext)
                        state_next = wrsi_pkg::ST_SDIFF;
                    else if (count_reg == '0)
                        state_next = wrsi_pkg::ST_DONE;
                    else
                        state_next = wrsi_pkg::ST_ACC;
                end
            end
            wrsi_pkg::ST_ACC:
                state_next = (count_reg == p_ext) ? wrsi_pkg::ST_WDIV : wrsi_pkg::ST_DONE;
            wrsi_pkg::ST_WDIV:
                if (div_done)
                    state_next = wrsi_pkg::ST_DONE;
            wrsi_pkg::ST_SDIFF:
                state_next = wrsi_pkg::ST_SDIV;
            wrsi_pkg::ST_SDIV:
                if (div_done)
                    state_next = wrsi_pkg::ST_NORM;
            wrsi_pkg::ST_NORM:
            begin
                priority if (both_zero)
                    state_next = wrsi_pkg::ST_DONE;
                else if (!need_shift)
                    state_next = wrsi_pkg::ST_RATIO;
            end
            wrsi_pkg::ST_RATIO:
                if (rat_done)
                    state_next = wrsi_pkg::ST_DONE;
            wrsi_pkg::ST_DONE:
                if (!m_tvalid_reg || m_tready)
                    state_next = wrsi_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        prev_next        = prev_reg;
        count_next       = count_reg;
        avg_g_next       = avg_g_reg;
        avg_l_next       = avg_l_reg;
        diff_next        = diff_reg;
        up_next          = up_reg;
        ge_g_next        = ge_g_reg;
        ge_l_next        = ge_l_reg;
        ng_next          = ng_reg;
        nl_next          = nl_reg;
        res_rsi_next     = res_rsi_reg;
        res_valid_next   = res_valid_reg;
        res_flat_next    = res_flat_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        m_rsi_next       = m_rsi_reg;
        m_valid_res_next = m_valid_res_reg;
        m_flat_next      = m_flat_reg;
        div_start        = 1'b0;
        rat_start        = 1'b0;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    prev_next      = close_in;
                    up_next        = close_up;
                    diff_next      = close_up ? close_in - prev_reg : prev_reg - close_in;
                    res_rsi_next   = '0;
                    res_valid_next = 1'b0;
                    res_flat_next  = 1'b0;
                    if (count_reg == '0)
                        count_next = count_reg + CW'(1);
                end
            end
            wrsi_pkg::ST_ACC:
            begin
                avg_g_next = sat_g;
                avg_l_next = sat_l;
                count_next = count_reg + CW'(1);
                if (count_reg == p_ext)
                    div_start = 1'b1;
            end
            wrsi_pkg::ST_WDIV:
            begin
                if (div_done)
                begin
                    avg_g_next = div_q_g;
                    avg_l_next = div_q_l;
                end
            end
            wrsi_pkg::ST_SDIFF:
            begin
                ge_g_next = sm_ge_g;
                ge_l_next = sm_ge_l;
                div_start = 1'b1;
            end
            wrsi_pkg::ST_SDIV:
            begin
                if (div_done)
                begin
                    avg_g_next = sm_new_g;
                    avg_l_next = sm_new_l;
                    ng_next    = sm_new_g;
                    nl_next    = sm_new_l;
                end
            end
            wrsi_pkg::ST_NORM:
            begin
                priority if (both_zero)
                begin
                    res_valid_next = 1'b1;
                    res_flat_next  = 1'b1;
                end
                else if (need_shift)
                begin
                    ng_next = ng_reg >> 1;
                    nl_next = nl_reg >> 1;
                end
                else
                    rat_start = 1'b1;
            end
            wrsi_pkg::ST_RATIO:
            begin
                if (rat_done)
                begin
                    res_rsi_next   = rat_q;
                    res_valid_next = 1'b1;
                end
            end
            wrsi_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next    = 1'b1;
                    m_rsi_next       = res_rsi_reg;
                    m_valid_res_next = res_valid_reg;
                    m_flat_next      = res_flat_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wrsi_pkg::ST_IDLE;
            period_reg   <= wrsi_pkg::PERIOD_RESET;
            prev_reg     <= '0;
            count_reg    <= '0;
            avg_g_reg    <= '0;
            avg_l_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
                period_reg <= cfg_data;
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            avg_g_reg    <= avg_g_next;
            avg_l_reg    <= avg_l_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg        <= diff_next;
        up_reg          <= up_next;
        ge_g_reg        <= ge_g_next;
        ge_l_reg        <= ge_l_next;
        ng_reg          <= ng_next;
        nl_reg          <= nl_next;
        res_rsi_reg     <= res_rsi_next;
        res_valid_reg   <= res_valid_next;
        res_flat_reg    <= res_flat_next;
        m_rsi_reg       <= m_rsi_next;
        m_valid_res_reg <= m_valid_res_next;
        m_flat_reg      <= m_flat_next;
    end

    wrsi_pdiv #(
        .WIDTH (AVG_BITS)
    ) u_div_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in_g),
        .divisor  (p_eff),
        .quotient (div_q_g),
        .stat     (div_st_g)
    );

    wrsi_pdiv #(
        .WIDTH (AVG_BITS)
    ) u_div_loss (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in_l),
        .divisor  (p_eff),
        .quotient (div_q_l),
        .stat     (div_st_l)
    );

    wrsi_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rat_start),
        .gain  (NW'(ng_reg)),
        .loss  (NW'(nl_reg)),
        .rsi   (rat_q),
        .done  (rat_done)
    );

    assign s_tready = state_reg == wrsi_pkg::ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_rsi_reg};
    assign m_tuser  = {m_flat_reg, m_valid_res_reg};

endmodule

`default_nettype wire

FILE: dv/wrsi_checker.sv
`timescale 1ns / 1ps

module wrsi_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0]   cfg_data,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [wrsi_pkg::S_TDATA_W-1:0]  s_tdata,   // close_price
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [wrsi_pkg::M_TDATA_W-1:0]  m_tdata,   // rsi_value, pad
    input  wire logic [wrsi_pkg::M_TUSER_W-1:0]  m_tuser,   // valid_res, flat
    output int                                   errors,
    output int                                   pending
);

    import wrsi_pkg::*;

    localparam int          AVG_W          = PRICE_BITS_DEF + FRACTION_BITS_DEF + PERIOD_W;
    localparam logic [63:0] AVG_MAX        = (64'd1 << AVG_W) - 64'd1;
    localparam logic [63:0] RSI_FULL_SCALE = 64'd25600;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             valid_res;
        logic             flat;
    } rsi_expect_t;

    logic [PERIOD_W-1:0] period_q;
    logic [CLOSE_W-1:0]  last_close;
    logic [COUNT_W-1:0]  bars_seen;
    logic [63:0]         avg_gain;
    logic [63:0]         avg_loss;
    rsi_expect_t         rsi_q[$];
    rsi_expect_t         want;

    function automatic logic [63:0] sum_capped(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > AVG_MAX) ? AVG_MAX : s;
    endfunction

    function automatic logic [63:0] wilder_smooth(input logic [63:0] avg,
                                                  input logic [63:0] mv,
                                                  input logic [63:0] p);
        logic [63:0] d;
        if (mv >= avg)
            return avg + (mv - avg) / p;
        d = avg - mv;
        return avg - (d / p + ((d % p) != 64'd0 ? 64'd1 : 64'd0));
    endfunction

    function automatic void predict_bar(input logic [CLOSE_W-1:0] close);
        logic [63:0] p;
        logic [63:0] up_mv;
        logic [63:0] down_mv;
        logic [63:0] g;
        logic [63:0] l;
        rsi_expect_t r;
        p       = (period_q < PERIOD_MIN) ? 64'(PERIOD_MIN) : 64'(period_q);
        up_mv   = '0;
        down_mv = '0;
        if (close > last_close)
            up_mv = 64'(close - last_close) << FRACTION_BITS_DEF;
        else
            down_mv = 64'(last_close - close) << FRACTION_BITS_DEF;
        last_close  = close;
        r.rsi       = '0;
        r.valid_res = 1'b0;
        r.flat      = 1'b0;
        if (bars_seen <= p)
        begin
            if (bars_seen != '0)
            begin
                avg_gain = sum_capped(avg_gain, up_mv);
                avg_loss = sum_capped(avg_loss, down_mv);
                if (bars_seen == p)
                begin
                    avg_gain = avg_gain / p;
                    avg_loss = avg_loss / p;
                end
            end
            bars_seen = bars_seen + 1'b1;
        end
        else
        begin
            avg_gain    = wilder_smooth(avg_gain, up_mv, p);
            avg_loss    = wilder_smooth(avg_loss, down_mv, p);
            g           = avg_gain;
            l           = avg_loss;
            r.valid_res = 1'b1;
            if (g == '0 && l == '0)
                r.flat = 1'b1;
            else
            begin
                while ((g >> NORM_LIMIT_BITS) != '0 || (l >> NORM_LIMIT_BITS) != '0)
                begin
                    g = g >> 1;
                    l = l >> 1;
                end
                r.rsi = RSI_W'((g * RSI_FULL_SCALE) / (g + l));
            end
        end
        rsi_q = {rsi_q, r};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_q   = PERIOD_RESET;
            last_close = '0;
            bars_seen  = '0;
            avg_gain   = '0;
            avg_loss   = '0;
            rsi_q.delete();
        end
        else
        begin
            if (cfg_we)
                period_q = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (rsi_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got rsi_value %0d tuser %b",
                             $time, m_tdata[RSI_W-1:0], m_tuser);
                end
                else
                begin
                    want = rsi_q.pop_front();
                    if (m_tdata[RSI_W-1:0] !== want.rsi)
                    begin
                        errors++;
                        $display("%0t: rsi_value expected %0d got %0d",
                                 $time, want.rsi, m_tdata[RSI_W-1:0]);
                    end
                    if (m_tuser[0] !== want.valid_res)
                    begin
                        errors++;
                        $display("%0t: valid_res expected %b got %b",
                                 $time, want.valid_res, m_tuser[0]);
                    end
                    if (m_tuser[1] !== want.flat)
                    begin
                        errors++;
                        $display("%0t: flat expected %b got %b", $time, want.flat, m_tuser[1]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_bar(s_tdata);
        end
        pending = rsi_q.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import wrsi_pkg::*;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [PERIOD_W-1:0]   cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;   // rsi_value, pad
    wire [M_TUSER_W-1:0]   m_tuser;   // valid_res, flat
    int                    errors;
    int                    pending;

    int                    burst_left = 0;
    int                    stall_left = 0;
    int                    open_left  = 0;
    int                    n;
    int                    k;
    int                    hold;
    logic [CLOSE_W-1:0]    price;
    logic [CLOSE_W-1:0]    step;
    logic [PERIOD_W-1:0]   phase_period [11] = '{10'd5, 10'd0, 10'd1, 10'd3, 10'd14, 10'd2,
                                                 10'd2, 10'd2, 10'd40, 10'd7, 10'd14};
    logic [CLOSE_W-1:0]    directed_bars [14] = '{
        32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
        32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    always #2 clk = ~clk;

    wilder_rsi_tracker_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wrsi_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always @(negedge clk)
    begin
        if (open_left > 0)
        begin
            open_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0:       open_left  = $urandom_range(50, 400);
                1, 2:    stall_left = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                           : $urandom_range(5, 40);
                default: ;
            endcase
        end
    end

    task automatic send_bar(input logic [CLOSE_W-1:0] bar_close);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                     : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= bar_close;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] value);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_period(PERIOD_MIN);
        foreach (directed_bars[i])
            send_bar(directed_bars[i]);

        // big sums at the top period, then a lower period skips the divide
        set_period(10'd1023);
        for (n = 0; n < 40; n++)
            send_bar(n[0] ? 32'hFFFF_FFFF : ($urandom_range(0, 3) == 0 ? $urandom : 32'h0));

        phase_period[6] = PERIOD_W'($urandom_range(2, 1023));
        phase_period[7] = PERIOD_W'($urandom_range(2, 60));
        for (k = 0; k < 11; k++)
        begin
            set_period(phase_period[k]);
            price = $urandom;
            hold  = 0;
            for (n = 0; n < 75; n++)
            begin
                if (hold > 0)
                    hold--;
                else
                begin
                    case ($urandom_range(0, 49))
                        0, 1: price = $urandom;
                        2:    hold  = $urandom_range(5, 60);
                        3:    price = '0;
                        4:    price = '1;
                        default:
                        begin
                            step = $urandom_range(0, 1 << $urandom_range(0, 20));
                            if ($urandom_range(0, 1))
                                price = (price > ~step) ? '1 : price + step;
                            else
                                price = (price < step) ? '0 : price - step;
                        end
                    endcase
                end
                send_bar(price);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
